@@ sv/qefa_pkg.sv @@
// Shared types and constants for the Fp2 arithmetic unit.
`timescale 1ns / 1ps
package qefa_pkg;

  typedef enum logic [1:0] {
    MODE_MUL  = 2'd0,
    MODE_SQR  = 2'd1,
    MODE_INV  = 2'd2,
    MODE_NONE = 2'd3
  } qefa_mode_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } qefa_op_t;

  typedef struct packed {
    logic     start;
    qefa_op_t op;
  } qefa_ctl_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NONRESIDUE = 1'd1;

  localparam logic [63:0] MODULUS_RST    = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] NONRESIDUE_RST = 64'd7;

endpackage

@@ sv/qefa_serial.sv @@
// Bit-serial modular multiplier and restoring divider sharing one accumulator and shift register.
`timescale 1ns / 1ps
module qefa_serial #(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qefa_pkg::qefa_ctl_t ctl,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  input  logic [W-1:0]        m,
  output logic                done,
  output logic [W-1:0]        res,
  output logic [W-1:0]        quo
);
  import qefa_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  qefa_op_t      op_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  sh_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  m_r;

  logic [W:0]    dbl;
  logic [W:0]    dbl_red;
  logic [W:0]    sum;
  logic [W:0]    trial;
  logic          ge;
  logic [W-1:0]  acc_nxt;

  always_comb begin
    // multiply: acc = 2*acc (+a) mod m, MSB of multiplier first
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a_r};
    if (sum >= {1'b0, m_r}) sum = sum - {1'b0, m_r};
    // divide: shift in next dividend bit, subtract divisor if it fits
    trial   = {acc_r, sh_r[W-1]};
    ge      = (trial >= {1'b0, m_r});
    if (op_r == OP_DIV) begin
      acc_nxt = ge ? W'(trial - {1'b0, m_r}) : trial[W-1:0];
    end else begin
      acc_nxt = sh_r[W-1] ? sum[W-1:0] : dbl_red[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        op_r   <= ctl.op;
        cnt_r  <= W[CW-1:0];
        acc_r  <= '0;
        quo_r  <= '0;
        sh_r   <= (ctl.op == OP_MUL) ? b : a;
        a_r    <= a;
        m_r    <= m;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        quo_r <= {quo_r[W-2:0], ge};
        sh_r  <= {sh_r[W-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;
  assign quo  = quo_r;

endmodule

@@ sv/quadratic_extension_field_alu_unit.sv @@
// Top level of the Fp2 arithmetic unit: channels, configuration and sequencer.
`timescale 1ns / 1ps
// Fp[u]/(u^2 - beta) arithmetic unit.
// Input stream: in_tuser carries the mode (0 multiply, 1 square, 2 inverse,
// 3 gives zero), in_tdata the two operands a and b as coefficient pairs.
// Output stream: one request per input, r_lo/r_hi in out_tdata and the
// not_invertible flag in out_tuser.
// Config channel: cfg_index 0 writes the modulus p, 1 writes beta. Write only
// while idle; cfg_ready is always high.
// One request at a time through a single bit-serial unit, which does every
// modular product or division (unit width W = ELEM_BITS):
//   setup reduction of five values mod p
//   multiply or square: 4 products
//   inverse: 3 products, then per Euclid step a divide and a product,
//   then 2 products
// A degenerate modulus (below 3) or mode 3 returns zero.
// Reset (synchronous, rst_n low) loads p = 2^64-2^32+1 and beta = 7, drops
// out_tvalid and returns the sequencer to idle.
// A finished result waits in the output register; a stalled receiver only
// holds the sequencer at its final state, no request is lost.
module quadratic_extension_field_alu_unit #(
  parameter int ELEM_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // a_lo, a_hi, b_lo, b_hi (lowest first), zero pad to bytes
  input  logic [((4*ELEM_BITS+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // r_lo, r_hi (lowest first), zero pad to bytes
  output logic [((2*ELEM_BITS+7)/8)*8-1:0] out_tdata,
  // not_invertible
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qefa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ELEM_BITS-1:0]           cfg_data
);
  import qefa_pkg::*;

  localparam int W     = ELEM_BITS;
  localparam int OUT_W = ((2*ELEM_BITS+7)/8)*8;

  typedef enum logic [4:0] {
    S_IDLE, S_RED,
    M_P0, M_P1, M_PS, M_BP, M_FIN,
    Q_CR, Q_BX, Q_DD, Q_BC, Q_FIN,
    I_X0, I_X1, I_BX, I_INIT, I_DIV, I_QM, I_CHK, I_RL, I_RH,
    S_OUT
  } state_t;

  function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fsub(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] md);
    return (x >= y) ? x - y : x - y + md;
  endfunction

  state_t       state_r;
  qefa_mode_t   mode_r;
  logic [2:0]   k_r;
  logic         pend_r;
  logic [W-1:0] mod_r, nres_r;
  logic [W-1:0] mm_r, bt_r, x0_r, x1_r, y0_r, y1_r;
  logic [W-1:0] t0_r, t1_r, t2_r, t3_r;
  logic [W-1:0] r0_r, r1_r, e0_r, e1_r;
  logic [W-1:0] rl_r, rh_r;
  logic         flag_r;
  logic         out_valid_r;
  logic [W-1:0] out_lo_r, out_hi_r;
  logic         out_flag_r;

  qefa_ctl_t    uctl;
  logic [W-1:0] ua, ub, um;
  logic         udone;
  logic [W-1:0] ures, uquo;
  logic         op_state;
  logic [W-1:0] qm;

  assign qm = (uquo >= mm_r) ? uquo - mm_r : uquo;

  // operand selection for the shared unit
  always_comb begin
    op_state = 1'b1;
    uctl.op  = OP_MUL;
    ua       = '0;
    ub       = '0;
    um       = mm_r;
    case (state_r)
      S_RED: begin
        uctl.op = OP_DIV;
        case (k_r)
          3'd0:    ua = bt_r;
          3'd1:    ua = x0_r;
          3'd2:    ua = x1_r;
          3'd3:    ua = y0_r;
          default: ua = y1_r;
        endcase
      end
      M_P0: begin ua = x0_r; ub = y0_r; end
      M_P1: begin ua = x1_r; ub = y1_r; end
      M_PS: begin ua = fadd(x0_r, x1_r, mm_r); ub = fadd(y0_r, y1_r, mm_r); end
      M_BP: begin ua = bt_r; ub = t1_r; end
      Q_CR: begin ua = x0_r; ub = x1_r; end
      Q_BX: begin ua = bt_r; ub = x1_r; end
      Q_DD: begin ua = fsub(x0_r, x1_r, mm_r); ub = fsub(x0_r, t1_r, mm_r); end
      Q_BC: begin ua = bt_r; ub = t0_r; end
      I_X0: begin ua = x0_r; ub = x0_r; end
      I_X1: begin ua = x1_r; ub = x1_r; end
      I_BX: begin ua = bt_r; ub = t1_r; end
      I_DIV: begin
        uctl.op  = OP_DIV;
        ua       = r0_r;
        um       = r1_r;
        op_state = (r1_r != '0);
      end
      I_QM: begin ua = qm; ub = e1_r; end
      I_RL: begin ua = x0_r; ub = e0_r; end
      I_RH: begin ua = fsub('0, x1_r, mm_r); ub = e0_r; end
      default: op_state = 1'b0;
    endcase
    uctl.start = op_state && !pend_r;
  end

  qefa_serial #(.W(W)) u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (uctl),
    .a     (ua),
    .b     (ub),
    .m     (um),
    .done  (udone),
    .res   (ures),
    .quo   (uquo)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_hi_r, out_lo_r});
  assign out_tuser  = out_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mod_r       <= MODULUS_RST[W-1:0];
      nres_r      <= NONRESIDUE_RST[W-1:0];
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODULUS:    mod_r  <= cfg_data;
          REG_NONRESIDUE: nres_r <= cfg_data;
          default: ;
        endcase
      end
      // S_OUT reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (uctl.start) pend_r <= 1'b1;
      if (udone) pend_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            x0_r   <= in_tdata[W-1:0];
            x1_r   <= in_tdata[2*W-1:W];
            y0_r   <= in_tdata[3*W-1:2*W];
            y1_r   <= in_tdata[4*W-1:3*W];
            bt_r   <= nres_r;
            mm_r   <= mod_r;
            mode_r <= qefa_mode_t'(in_tuser);
            k_r    <= 3'd0;
            rl_r   <= '0;
            rh_r   <= '0;
            flag_r <= 1'b0;
            if (mod_r < W'(3) || qefa_mode_t'(in_tuser) == MODE_NONE) state_r <= S_OUT;
            else state_r <= S_RED;
          end
        end
        S_RED: if (udone) begin
          case (k_r)
            3'd0:    bt_r <= ures;
            3'd1:    x0_r <= ures;
            3'd2:    x1_r <= ures;
            3'd3:    y0_r <= ures;
            default: y1_r <= ures;
          endcase
          k_r <= k_r + 3'd1;
          if (k_r == 3'd4) begin
            case (mode_r)
              MODE_MUL: state_r <= M_P0;
              MODE_SQR: state_r <= Q_CR;
              default:  state_r <= I_X0;
            endcase
          end
        end
        // Karatsuba multiply
        M_P0: if (udone) begin t0_r <= ures; state_r <= M_P1; end
        M_P1: if (udone) begin t1_r <= ures; state_r <= M_PS; end
        M_PS: if (udone) begin t2_r <= ures; state_r <= M_BP; end
        M_BP: if (udone) begin t3_r <= ures; state_r <= M_FIN; end
        M_FIN: begin
          rl_r    <= fadd(t0_r, t3_r, mm_r);
          rh_r    <= fsub(fsub(t2_r, t0_r, mm_r), t1_r, mm_r);
          state_r <= S_OUT;
        end
        // complex squaring
        Q_CR: if (udone) begin t0_r <= ures; state_r <= Q_BX; end
        Q_BX: if (udone) begin t1_r <= ures; state_r <= Q_DD; end
        Q_DD: if (udone) begin t2_r <= ures; state_r <= Q_BC; end
        Q_BC: if (udone) begin t3_r <= ures; state_r <= Q_FIN; end
        Q_FIN: begin
          rl_r    <= fadd(fadd(t2_r, t0_r, mm_r), t3_r, mm_r);
          rh_r    <= fadd(t0_r, t0_r, mm_r);
          state_r <= S_OUT;
        end
        // inverse: norm, extended Euclid, conjugate times norm inverse
        I_X0: if (udone) begin t0_r <= ures; state_r <= I_X1; end
        I_X1: if (udone) begin t1_r <= ures; state_r <= I_BX; end
        I_BX: if (udone) begin t1_r <= ures; state_r <= I_INIT; end
        I_INIT: begin
          r0_r    <= mm_r;
          r1_r    <= fsub(t0_r, t1_r, mm_r);
          e0_r    <= '0;
          e1_r    <= W'(1);
          state_r <= I_DIV;
        end
        I_DIV: begin
          if (r1_r == '0) state_r <= I_CHK;
          else if (udone) begin
            t3_r    <= ures;
            state_r <= I_QM;
          end
        end
        I_QM: if (udone) begin
          e1_r    <= fsub(e0_r, ures, mm_r);
          e0_r    <= e1_r;
          r0_r    <= r1_r;
          r1_r    <= t3_r;
          state_r <= I_DIV;
        end
        I_CHK: begin
          if (r0_r != W'(1)) begin
            flag_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= I_RL;
          end
        end
        I_RL: if (udone) begin rl_r <= ures; state_r <= I_RH; end
        I_RH: if (udone) begin rh_r <= ures; state_r <= S_OUT; end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_lo_r    <= rl_r;
            out_hi_r    <= rh_r;
            out_flag_r  <= flag_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
